// ----- hw/rtl/dwb_pkg.sv -----
// Package for the data cache write buffer.
// Holds the fixed field widths and the command and status codes.
// No dependencies; every other file imports it.
package dwb_pkg;

  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 32;
  localparam int DATA_W   = 32;
  localparam int WIDX_W   = 3;
  localparam int BE_W     = 4;
  localparam int STATUS_W = 3;
  localparam int OWORD_W  = 3;
  localparam int FREE_W   = 4;
  // Word offset taken from the byte offset of a line of at most 64 bytes.
  localparam int RAWOFF_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_MERGE = 3'd2,
    CMD_DRAIN = 3'd3,
    CMD_RESP  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOMATCH   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_NODRAIN   = 3'd5
  } status_t;

endpackage

// ----- hw/rtl/dwb_in_if.sv -----
// Request channel of the write buffer: valid/ready handshake and one request.
// Depends on dwb_pkg for the field widths.
interface dwb_in_if import dwb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] addr;
  logic [WIDX_W-1:0] word_index;
  logic [DATA_W-1:0] data;
  logic [BE_W-1:0]   byte_enable;
  logic              line_end;

  modport source (output valid, cmd, addr, word_index, data, byte_enable, line_end,
                  input ready);
  modport sink   (input valid, cmd, addr, word_index, data, byte_enable, line_end,
                  output ready);
endinterface

// ----- hw/rtl/dwb_out_if.sv -----
// Result channel of the write buffer: valid/ready handshake and one result.
// Depends on dwb_pkg for the field widths.
interface dwb_out_if import dwb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_data;
  logic [ADDR_W-1:0]   drain_line;
  logic [OWORD_W-1:0]  out_word;
  logic                is_last;
  logic [FREE_W-1:0]   free_slots;

  modport source (output valid, status, read_data, drain_line, out_word, is_last, free_slots,
                  input ready);
  modport sink   (input valid, status, read_data, drain_line, out_word, is_last, free_slots,
                  output ready);
endinterface

// ----- hw/rtl/dcache_write_buffer.sv -----
// Write buffer for evicted dirty lines: a circular FIFO of ENTRIES lines of
// WORDS_PER_LINE words. Each transaction on in_chan carries one request (push a
// word, bypass read, byte-merge a store, drain the head line, write response).
// A request is captured when taken and executed in the execute state, which
// waits while the output register is full or a read result is pending; a merge
// adds a further state to write the modified word back into the single data
// memory, whose read data is registered. A drain emits its WORDS_PER_LINE
// results one per cycle after the execute state while out_chan keeps taking
// them. The line addresses sit in flip-flops and are compared in parallel; the
// data memory needs no clearing after reset, so the block takes requests as
// soon as reset is released.
module dcache_write_buffer import dwb_pkg::*; #(
  parameter int ENTRIES        = 8,
  parameter int WORDS_PER_LINE = 8,
  parameter int LINE_BYTES     = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  dwb_in_if.sink    in_chan,
  dwb_out_if.source out_chan
);

  localparam int SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OFS_W     = SLOT_W + 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int WORD_W    = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int MEM_DEPTH = ENTRIES * WORDS_PER_LINE;
  localparam int MADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int RAWOFF_N  = 1 << RAWOFF_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MERGE, S_DRAIN} state_t;

  // Control state
  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               dp_r, dp_nxt;
  logic [WORD_W-1:0]  wcnt_r;
  logic               rd_pend_r;

  // Captured request
  cmd_t               cmd_r;
  logic [ADDR_W-1:0]  line_r;
  logic [WORD_W-1:0]  woff_r;
  logic [WORD_W-1:0]  widx_r;
  logic               widx_ok_r;
  logic [DATA_W-1:0]  data_r;
  logic [BE_W-1:0]    be_r;
  logic               lend_r;
  logic [ENTRIES-1:0] mvec_r;
  logic [MADDR_W-1:0] maddr_r;

  // Read metadata travelling with the memory read data
  logic [ADDR_W-1:0]  rd_line_r;
  logic [OWORD_W-1:0] rd_word_r;
  logic               rd_last_r;
  logic [DATA_W-1:0]  rdata_r;

  // Output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [DATA_W-1:0]   out_rdata_r;
  logic [ADDR_W-1:0]   out_line_r;
  logic [OWORD_W-1:0]  out_word_r;
  logic                out_last_r;
  logic [FREE_W-1:0]   out_free_r;

  logic [ADDR_W-1:0]  entry_addr_r [ENTRIES];
  logic [DATA_W-1:0]  mem [MEM_DEPTH];

  logic [WORD_W-1:0]  woff_tbl [RAWOFF_N];
  logic [RAWOFF_W-1:0] in_rawoff;
  logic [ADDR_W-1:0]  in_line;
  logic [ENTRIES-1:0] in_mvec;
  logic               in_acc;

  logic               out_free, rd_load, exec_go, merge_go, drain_issue, drain_last;
  logic               hit, busy, full, rd_issue;
  logic [ENTRIES-1:0] below_head, lo_vec;
  logic [SLOT_W-1:0]  hslot, tail, head_inc;
  logic [MADDR_W-1:0] mem_raddr, mem_waddr, hit_maddr;
  logic               mem_re, mem_we;
  logic [DATA_W-1:0]  mem_wdata, merge_mask;
  logic               ex_emit;
  status_t            ex_status;

  function automatic logic [SLOT_W-1:0] top_set(input logic [ENTRIES-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [MADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [WORD_W-1:0] word);
    return MADDR_W'(MADDR_W'(slot) * MADDR_W'(WORDS_PER_LINE)) + MADDR_W'(word);
  endfunction

  function automatic logic [FREE_W-1:0] free_of(input logic [CNT_W-1:0] fill);
    return FREE_W'(32'(ENTRIES) - 32'(fill));
  endfunction

  // Word offset within the line, reduced modulo the line length.
  for (genvar gi = 0; gi < RAWOFF_N; gi++) begin : g_woff
    assign woff_tbl[gi] = WORD_W'(gi % WORDS_PER_LINE);
  end

  // Tag compare against committed slots, done as the request is taken.
  always_comb begin
    logic [OFS_W-1:0] ofs;
    in_line   = in_chan.addr & ~ADDR_W'(LINE_BYTES - 1);
    in_rawoff = RAWOFF_W'((in_chan.addr & ADDR_W'(LINE_BYTES - 1)) >> 2);
    for (int s = 0; s < ENTRIES; s++) begin
      if (SLOT_W'(s) >= head_r) ofs = OFS_W'(s) - OFS_W'(head_r);
      else                      ofs = OFS_W'(s) + OFS_W'(ENTRIES) - OFS_W'(head_r);
      in_mvec[s] = (32'(ofs) < 32'(fill_r)) && (entry_addr_r[s] == in_line);
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Youngest match: slots below the head pointer have wrapped and are younger.
  always_comb begin
    for (int s = 0; s < ENTRIES; s++) begin
      below_head[s] = (SLOT_W'(s) < head_r);
    end
    lo_vec = mvec_r & below_head;
    hslot  = (|lo_vec) ? top_set(lo_vec) : top_set(mvec_r);
  end

  always_comb begin
    logic [OFS_W-1:0] tsum;
    tsum = OFS_W'(head_r) + OFS_W'(fill_r);
    if (32'(tsum) >= 32'(ENTRIES)) tsum = tsum - OFS_W'(ENTRIES);
    tail     = SLOT_W'(tsum);
    head_inc = (32'(head_r) == ENTRIES - 1) ? '0 : head_r + SLOT_W'(1);
  end

  assign hit        = |mvec_r;
  assign busy       = (hslot == head_r) && dp_r;
  assign full       = (32'(fill_r) >= 32'(ENTRIES));
  assign out_free   = !out_valid_r || out_chan.ready;
  assign rd_load    = rd_pend_r && out_free;
  assign exec_go    = (state_r == S_EXEC) && out_free && !rd_pend_r;
  assign merge_go   = (state_r == S_MERGE) && out_free;
  assign drain_issue = (state_r == S_DRAIN) && (!rd_pend_r || rd_load);
  assign drain_last = (32'(wcnt_r) == WORDS_PER_LINE - 1);
  assign rd_issue   = (exec_go && cmd_r == CMD_READ && hit) || drain_issue;
  assign hit_maddr  = word_addr(hslot, woff_r);

  // Execute step: next control state and the directly produced result.
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    dp_nxt    = dp_r;
    ex_emit   = 1'b0;
    ex_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
          ex_emit   = 1'b1;
          case (cmd_r)
            CMD_PUSH: begin
              if (full) ex_status = ST_OVERFLOW;
              else if (lend_r) fill_nxt = fill_r + CNT_W'(1);
            end
            CMD_READ: begin
              // A hit goes out through the memory read path instead.
              if (!hit) ex_status = ST_NOMATCH;
              else      ex_emit   = 1'b0;
            end
            CMD_MERGE: begin
              if (!hit)     ex_status = ST_NOMATCH;
              else if (busy) ex_status = ST_BUSY;
              else begin
                ex_emit   = 1'b0;
                state_nxt = S_MERGE;
              end
            end
            CMD_DRAIN: begin
              if (dp_r || fill_r == '0) ex_status = ST_NODRAIN;
              else begin
                ex_emit   = 1'b0;
                dp_nxt    = 1'b1;
                state_nxt = S_DRAIN;
              end
            end
            CMD_RESP: begin
              dp_nxt = 1'b0;
              if (fill_r == '0) ex_status = ST_UNDERFLOW;
              else begin
                fill_nxt = fill_r - CNT_W'(1);
                head_nxt = head_inc;
              end
            end
            default: ex_status = ST_NOMATCH;
          endcase
        end
      end
      S_MERGE: begin
        if (merge_go) begin
          state_nxt = S_IDLE;
          ex_emit   = 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain_issue && drain_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    for (int b = 0; b < BE_W; b++) begin
      merge_mask[8*b +: 8] = {8{be_r[b]}};
    end
  end

  assign mem_re    = rd_issue || (exec_go && cmd_r == CMD_MERGE && hit && !busy);
  assign mem_raddr = drain_issue ? word_addr(head_r, wcnt_r) : hit_maddr;
  assign mem_we    = (exec_go && cmd_r == CMD_PUSH && !full && widx_ok_r) || merge_go;
  assign mem_waddr = merge_go ? maddr_r : word_addr(tail, widx_r);
  assign mem_wdata = merge_go ? ((rdata_r & ~merge_mask) | (data_r & merge_mask)) : data_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (exec_go && cmd_r == CMD_PUSH && !full) entry_addr_r[tail] <= line_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      dp_r        <= 1'b0;
      wcnt_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      dp_r    <= dp_nxt;

      if (in_acc) begin
        cmd_r     <= cmd_t'(in_chan.cmd);
        line_r    <= in_line;
        woff_r    <= woff_tbl[in_rawoff];
        widx_r    <= WORD_W'(in_chan.word_index);
        widx_ok_r <= (32'(in_chan.word_index) < WORDS_PER_LINE);
        data_r    <= in_chan.data;
        be_r      <= in_chan.byte_enable;
        lend_r    <= in_chan.line_end;
        mvec_r    <= in_mvec;
      end

      if (exec_go) begin
        maddr_r <= hit_maddr;
        wcnt_r  <= '0;
      end else if (drain_issue) begin
        wcnt_r <= wcnt_r + WORD_W'(1);
      end

      if (rd_issue) begin
        rd_pend_r <= 1'b1;
        if (drain_issue) begin
          rd_line_r <= entry_addr_r[head_r];
          rd_word_r <= OWORD_W'(wcnt_r);
          rd_last_r <= drain_last;
        end else begin
          rd_line_r <= '0;
          rd_word_r <= '0;
          rd_last_r <= 1'b1;
        end
      end else if (rd_load) begin
        rd_pend_r <= 1'b0;
      end

      // The memory path and the direct path never load in the same cycle.
      if (rd_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= ST_OK;
        out_rdata_r  <= rdata_r;
        out_line_r   <= rd_line_r;
        out_word_r   <= rd_word_r;
        out_last_r   <= rd_last_r;
        out_free_r   <= free_of(fill_r);
      end else if (ex_emit) begin
        out_valid_r  <= 1'b1;
        out_status_r <= ex_status;
        out_rdata_r  <= '0;
        out_line_r   <= '0;
        out_word_r   <= '0;
        out_last_r   <= 1'b1;
        out_free_r   <= free_of(fill_nxt);
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.read_data  = out_rdata_r;
  assign out_chan.drain_line = out_line_r;
  assign out_chan.out_word   = out_word_r;
  assign out_chan.is_last    = out_last_r;
  assign out_chan.free_slots = out_free_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= ENTRIES)
    else $error("write buffer fill count above capacity");

  a_drain_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> dp_r)
    else $error("drain running without its in-flight flag");

  a_merge_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> !rd_pend_r)
    else $error("merge write-back overlaps a pending read result");

  a_rd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    rd_load |=> out_valid_r)
    else $error("memory read result lost on its way to the output");

endmodule
